[design/afrr_pkg.sv]
// Shared types, constants and helpers for the ASCII frame response receiver.
`default_nettype none
package afrr_pkg;

  // Field and register widths.
  localparam int BYTE_W   = 8;
  localparam int FC_W     = 13;
  localparam int HDR_W    = 4;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;

  // Frame length at which a frame is flagged too long.
  localparam logic [FC_W-1:0] MAX_FRAME = FC_W'(4096);

  // Register reset values.
  localparam logic [FC_W-1:0]  MIN_FRAME_RST = FC_W'(14);
  localparam logic [HDR_W-1:0] HDR_LEN_RST   = HDR_W'(4);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_LEN   = 1'b1;

  // Control characters.
  localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;

  // Frame status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ACK      = 3'd1,
    ST_NAK      = 3'd2,
    ST_SUM_BAD  = 3'd3,
    ST_SHORT    = 3'd4,
    ST_BAD_LEAD = 3'd5,
    ST_FRAMING  = 3'd6,
    ST_TOO_LONG = 3'd7
  } status_t;

  // Lead byte kinds.
  localparam logic [1:0] LEAD_DATA  = 2'd0;
  localparam logic [1:0] LEAD_ACK   = 2'd1;
  localparam logic [1:0] LEAD_NAK   = 2'd2;
  localparam logic [1:0] LEAD_OTHER = 2'd3;

  // One result of the byte processing step.
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
    logic              payload;
    logic              done;
    status_t           status;
  } result_t;

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

[design/afrr_core.sv]
// Per-byte frame state machine: holds frame state and computes one result.
`default_nettype none
module afrr_core
  import afrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [FC_W-1:0]   min_frame,
  input  wire logic [HDR_W-1:0]  hdr_len,
  output result_t                res
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_DATA     = 4'd1,
    PH_SUM_HI   = 4'd2,
    PH_SUM_LO   = 4'd3,
    PH_DATA_CR  = 4'd4,
    PH_DATA_LF  = 4'd5,
    PH_CTL_BODY = 4'd6,
    PH_CTL_LF   = 4'd7,
    PH_DISCARD  = 4'd8
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [FC_W-1:0]   cnt_r, cnt_nxt;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [BYTE_W-1:0] shc_r, shc_nxt;
  logic [1:0]        lead_r, lead_nxt;
  logic [FC_W-1:0]   cnt_inc;
  logic              too_long;
  logic              sum_match;

  // Saturating frame byte count and checksum compare.
  assign cnt_inc   = (cnt_r < MAX_FRAME) ? cnt_r + FC_W'(1) : cnt_r;
  assign too_long  = (cnt_inc >= MAX_FRAME);
  assign sum_match = (shc_r == hex_char(sum_r[7:4])) && (rx_byte == hex_char(sum_r[3:0]));

  // Next state and result for the byte at hand.
  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    hdr_nxt     = hdr_r;
    shc_nxt     = shc_r;
    lead_nxt    = lead_r;
    res.vld     = 1'b0;
    res.data    = '0;
    res.payload = 1'b0;
    res.done    = 1'b0;
    res.status  = ST_OK;
    if (step) begin
      if (phase_r == PH_IDLE) begin
        cnt_nxt = FC_W'(1);
        sum_nxt = '0;
        shc_nxt = '0;
        if (rx_byte == CH_STX) begin
          lead_nxt  = LEAD_DATA;
          hdr_nxt   = hdr_len;
          phase_nxt = PH_DATA;
        end else if (rx_byte == CH_ACK || rx_byte == CH_NAK) begin
          lead_nxt  = (rx_byte == CH_ACK) ? LEAD_ACK : LEAD_NAK;
          phase_nxt = PH_CTL_BODY;
        end else begin
          lead_nxt = LEAD_OTHER;
          if (rx_byte == CH_LF) begin
            res.vld    = 1'b1;
            res.done   = 1'b1;
            res.status = ST_BAD_LEAD;
          end else begin
            phase_nxt = PH_DISCARD;
          end
        end
      end else begin
        cnt_nxt = cnt_inc;
        case (phase_r)
          PH_DATA: begin
            sum_nxt = sum_r + rx_byte;
            if (rx_byte == CH_ETX) begin
              phase_nxt = PH_SUM_HI;
            end else if (hdr_r != '0) begin
              hdr_nxt = hdr_r - HDR_W'(1);
            end else begin
              res.vld     = 1'b1;
              res.data    = rx_byte;
              res.payload = 1'b1;
            end
          end
          PH_SUM_HI: begin
            shc_nxt   = rx_byte;
            phase_nxt = PH_SUM_LO;
          end
          PH_SUM_LO: begin
            shc_nxt   = {7'd0, sum_match};
            phase_nxt = PH_DATA_CR;
          end
          PH_DATA_CR: begin
            if (rx_byte != CH_CR) begin
              res.vld    = 1'b1;
              res.done   = 1'b1;
              res.status = ST_FRAMING;
              phase_nxt  = PH_IDLE;
            end else begin
              phase_nxt = PH_DATA_LF;
            end
          end
          PH_DATA_LF: begin
            res.vld   = 1'b1;
            res.done  = 1'b1;
            phase_nxt = PH_IDLE;
            if (rx_byte != CH_LF) begin
              res.status = ST_FRAMING;
            end else if (too_long) begin
              res.status = ST_TOO_LONG;
            end else if (cnt_inc < min_frame) begin
              res.status = ST_SHORT;
            end else if (shc_r == 8'd1) begin
              res.status = ST_OK;
            end else begin
              res.status = ST_SUM_BAD;
            end
          end
          PH_CTL_BODY: begin
            if (rx_byte == CH_CR) begin
              phase_nxt = PH_CTL_LF;
            end
          end
          PH_CTL_LF: begin
            if (rx_byte == CH_LF) begin
              res.vld    = 1'b1;
              res.done   = 1'b1;
              res.status = too_long ? ST_TOO_LONG : status_t'({1'b0, lead_r});
              phase_nxt  = PH_IDLE;
            end else if (rx_byte != CH_CR) begin
              phase_nxt = PH_CTL_BODY;
            end
          end
          PH_DISCARD: begin
            if (rx_byte == CH_LF) begin
              res.vld    = 1'b1;
              res.done   = 1'b1;
              res.status = too_long ? ST_TOO_LONG : ST_BAD_LEAD;
              phase_nxt  = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      hdr_r   <= '0;
      shc_r   <= '0;
      lead_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
      shc_r   <= shc_nxt;
      lead_r  <= lead_nxt;
    end
  end

`ifndef SYNTH
  // The frame count never passes its saturation point.
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAX_FRAME)
    else $error("frame count above saturation point");

  // A frame status always sends the machine back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done) |=> (phase_r == PH_IDLE))
    else $error("frame ended without returning to idle");

  // Payload bytes only come out of the data phase, never with a status.
  a_payload_src: assert property (@(posedge clk) disable iff (!rst_n)
    res.payload |-> (phase_r == PH_DATA && !res.done))
    else $error("payload result outside data phase");

  // After a checksum pair the match flag is a single bit.
  a_match_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA_CR || phase_r == PH_DATA_LF) |-> (shc_r[7:1] == 7'd0))
    else $error("checksum match flag corrupted");
`endif

endmodule
`default_nettype wire

[design/ascii_frame_response_receiver_unit.sv]
// A byte passes the input register, then its result is held in the result register;
// only payload bytes and bytes that end a frame give a result.
// Throughput: one byte per cycle; a stalled result holds input once the input register is full.
// Reset (synchronous, active low) returns to idle, empties both registers and
// restores min_frame_length 14 and header_length 4.
`default_nettype none
module ascii_frame_response_receiver_unit
  import afrr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BYTE_W-1:0]         out_byte,
  output logic                      out_is_payload,
  output logic                      out_frame_done,
  output logic [2:0]                out_status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  result_t           out_r;
  logic [FC_W-1:0]   min_frame_r;
  logic [HDR_W-1:0]  hdr_len_r;
  logic              advance;
  result_t           res;

  // The held byte moves on whenever the result register is free or draining.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_frame_r <= MIN_FRAME_RST;
      hdr_len_r   <= HDR_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MIN_FRAME) begin
        min_frame_r <= cfg_wdata[FC_W-1:0];
      end else if (cfg_index == REG_HDR_LEN) begin
        hdr_len_r <= cfg_wdata[HDR_W-1:0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Frame state machine.
  afrr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .min_frame (min_frame_r),
    .hdr_len   (hdr_len_r),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res.vld;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_byte       = out_r.data;
  assign out_is_payload = out_r.payload;
  assign out_frame_done = out_r.done;
  assign out_status     = out_r.status;

endmodule
`default_nettype wire
